FILE: sv/nce_pkg.sv
package nce_pkg;

   // default table size
   localparam int ENTRIES_DEFAULT = 16;

   // field widths
   localparam int ADDR_W  = 64;
   localparam int MAC_W   = 48;
   localparam int STAMP_W = 48;
   localparam int TMO_W   = 32;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;

   // timeout after reset, in ms
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(300000);

   // largest live count that the result word can carry
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // operation codes
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // one table entry as stored in the RAM
   typedef struct packed {
      logic [ADDR_W-1:0]  ip_high;
      logic [ADDR_W-1:0]  ip_low;
      logic [MAC_W-1:0]   mac;
      logic [STAMP_W-1:0] stamp;
      logic               router;
   } nce_entry_type;

   localparam int ENTRY_W = $bits(nce_entry_type);

   // controller to datapath
   typedef struct packed {
      logic start;    // capture request word, begin table scan
      logic commit;   // write back entry and load result word
   } nce_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;  // last entry evaluated this cycle
      logic out_free;   // result register can take a new word
   } nce_status_type;

endpackage

FILE: sv/neighbor_cache_engine.sv
// IPv6 neighbor cache: a table of ENTRIES slots mapping a 128-bit address to a
// 48-bit MAC, a 48-bit ms stamp and a router flag, held in one RAM with valid
// bits in flops (reset clears them at once, no clearing pass). One request
// word is handled at a time: a new request is not taken until the last one
// has written back and loaded its result. The single RAM read port is swept
// one entry per cycle to find the match, the first free slot, the oldest
// stamp and the live count; then, once the result register is free, an
// update writes its entry back and the result register is loaded. The next
// request is accepted while a result still waits to be taken; its write-back
// waits until that result is gone. The user must write timeout_ms through
// csr_wr_en/csr_wr_data only while idle; the block does not enforce this.
module neighbor_cache_engine #(
   parameter int ENTRIES = nce_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [nce_pkg::TMO_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [nce_pkg::ADDR_W-1:0]        req_ip_high,
   input  logic [nce_pkg::ADDR_W-1:0]        req_ip_low,
   input  logic [nce_pkg::MAC_W-1:0]         req_mac_in,
   input  logic                              req_router_in,
   input  logic [nce_pkg::STAMP_W-1:0]       req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic                              rsp_expired,
   output logic [nce_pkg::MAC_W-1:0]         rsp_mac_out,
   output logic                              rsp_router_out,
   output logic [nce_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [nce_pkg::COUNT_W-1:0]       rsp_live_count
);
   import nce_pkg::*;

   nce_cmd_type    cmd;
   nce_status_type status;

   // sequencer
   nce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table, scan and result path
   nce_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_cmd        (req_cmd),
      .req_ip_high    (req_ip_high),
      .req_ip_low     (req_ip_low),
      .req_mac_in     (req_mac_in),
      .req_router_in  (req_router_in),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_expired    (rsp_expired),
      .rsp_mac_out    (rsp_mac_out),
      .rsp_router_out (rsp_router_out),
      .rsp_slot       (rsp_slot),
      .rsp_live_count (rsp_live_count)
   );

endmodule

FILE: sv/nce_ram.sv
module nce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/nce_ctrl.sv
module nce_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  nce_pkg::nce_status_type status,
   output nce_pkg::nce_cmd_type    cmd
);
   import nce_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SCAN))
      else $error("accepted word did not start a scan");

   a_commit_idles: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE))
      else $error("commit did not return to idle");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
`endif

endmodule

FILE: sv/nce_dpath.sv
module nce_dpath #(
   parameter int ENTRIES = nce_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nce_pkg::nce_cmd_type              cmd,
   output nce_pkg::nce_status_type           status,
   input  logic                              csr_wr_en,
   input  logic [nce_pkg::TMO_W-1:0]         csr_wr_data,
   input  logic                              req_cmd,
   input  logic [nce_pkg::ADDR_W-1:0]        req_ip_high,
   input  logic [nce_pkg::ADDR_W-1:0]        req_ip_low,
   input  logic [nce_pkg::MAC_W-1:0]         req_mac_in,
   input  logic                              req_router_in,
   input  logic [nce_pkg::STAMP_W-1:0]       req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic                              rsp_expired,
   output logic [nce_pkg::MAC_W-1:0]         rsp_mac_out,
   output logic                              rsp_router_out,
   output logic [nce_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [nce_pkg::COUNT_W-1:0]       rsp_live_count
);
   import nce_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   // timeout register
   logic [TMO_W-1:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // captured request word
   logic                cmd_ff;
   logic [ADDR_W-1:0]   ip_high_ff;
   logic [ADDR_W-1:0]   ip_low_ff;
   logic [MAC_W-1:0]    mac_ff;
   logic                router_ff;
   logic [STAMP_W-1:0]  now_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cmd_ff     <= req_cmd;
         ip_high_ff <= req_ip_high;
         ip_low_ff  <= req_ip_low;
         mac_ff     <= req_mac_in;
         router_ff  <= req_router_in;
         now_ff     <= req_now_ms;
      end
   end

   // table storage
   logic [ENTRIES-1:0] valid_ff;
   logic               wr_en;
   logic [IW-1:0]      wr_idx;
   nce_entry_type      wr_entry;
   logic [ENTRY_W-1:0] rd_word;
   nce_entry_type      rd_entry;
   logic [IW-1:0]      rd_ptr_ff;

   nce_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;

   // read sequencer: one address per cycle, data in the following cycle
   logic          rd_busy_ff;
   logic          eval_ff;
   logic [IW-1:0] eval_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_busy_ff <= 1'b0;
         eval_ff    <= 1'b0;
      end else begin
         eval_ff <= rd_busy_ff;
         if (cmd.start) begin
            rd_busy_ff <= 1'b1;
         end else if (rd_busy_ff && rd_ptr_ff == LAST_IDX) begin
            rd_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= rd_ptr_ff;
      if (cmd.start) begin
         rd_ptr_ff <= '0;
      end else if (rd_busy_ff && rd_ptr_ff != LAST_IDX) begin
         rd_ptr_ff <= rd_ptr_ff + IW'(1);
      end
   end

   assign status.scan_done = eval_ff && (eval_idx_ff == LAST_IDX);

   // per-entry evaluation
   logic               cur_valid;
   logic               cur_match;
   logic               cur_live;
   logic [STAMP_W-1:0] cur_age;

   assign cur_valid = valid_ff[eval_idx_ff];
   assign cur_match = cur_valid && (rd_entry.ip_high == ip_high_ff)
                      && (rd_entry.ip_low == ip_low_ff);
   assign cur_age   = now_ff - rd_entry.stamp;
   assign cur_live  = cur_valid && (cur_age <= {{(STAMP_W-TMO_W){1'b0}}, timeout_ff});

   // scan results
   logic               match_found_ff;
   logic [IW-1:0]      match_idx_ff;
   logic [MAC_W-1:0]   match_mac_ff;
   logic               match_rtr_ff;
   logic               match_live_ff;
   logic               free_found_ff;
   logic [IW-1:0]      free_idx_ff;
   logic               old_have_ff;
   logic [IW-1:0]      old_idx_ff;
   logic [STAMP_W-1:0] old_stamp_ff;
   logic               old_live_ff;
   logic [CW-1:0]      live_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         old_have_ff    <= 1'b0;
         live_cnt_ff    <= '0;
      end else if (eval_ff) begin
         if (cur_match && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= eval_idx_ff;
            match_mac_ff   <= rd_entry.mac;
            match_rtr_ff   <= rd_entry.router;
            match_live_ff  <= cur_live;
         end
         if (!cur_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= eval_idx_ff;
         end
         // strictly older only, so ties keep the lower index
         if (cur_valid && (!old_have_ff || rd_entry.stamp < old_stamp_ff)) begin
            old_have_ff  <= 1'b1;
            old_idx_ff   <= eval_idx_ff;
            old_stamp_ff <= rd_entry.stamp;
            old_live_ff  <= cur_live;
         end
         if (cur_live) begin
            live_cnt_ff <= live_cnt_ff + CW'(1);
         end
      end
   end

   // write-back and result word
   logic [IW+SLOT_W-1:0] slot_ext;
   logic                 live_w;
   logic [CW:0]          cnt_new;
   logic [CW+COUNT_W:0]  cnt_ext;
   logic                 hit_in;
   logic                 expired_in;
   logic [MAC_W-1:0]     mac_out_in;
   logic                 router_out_in;
   logic [IW-1:0]        slot_idx;
   logic                 clear_en;
   logic [COUNT_W-1:0]   count_in;

   always_comb begin
      wr_idx        = old_idx_ff;
      live_w        = old_live_ff;
      hit_in        = 1'b0;
      expired_in    = 1'b0;
      mac_out_in    = '0;
      router_out_in = 1'b0;
      slot_idx      = '0;
      clear_en      = 1'b0;
      wr_en         = 1'b0;
      cnt_new       = {1'b0, live_cnt_ff};
      if (cmd_ff == CMD_UPDATE) begin
         priority if (match_found_ff) begin
            wr_idx = match_idx_ff;
            live_w = match_live_ff;
         end else if (free_found_ff) begin
            wr_idx = free_idx_ff;
            live_w = 1'b0;
         end else begin
            wr_idx = old_idx_ff;
            live_w = old_live_ff;
         end
         wr_en    = cmd.commit;
         slot_idx = wr_idx;
         // written entry is fresh and always live
         cnt_new  = {1'b0, live_cnt_ff} + (CW+1)'(1) - {{CW{1'b0}}, live_w};
      end else if (match_found_ff) begin
         slot_idx = match_idx_ff;
         if (match_live_ff) begin
            hit_in        = 1'b1;
            mac_out_in    = match_mac_ff;
            router_out_in = match_rtr_ff;
         end else begin
            expired_in = 1'b1;
            clear_en   = cmd.commit;
         end
      end
      slot_ext = {{SLOT_W{1'b0}}, slot_idx};
      cnt_ext  = {{COUNT_W{1'b0}}, cnt_new};
      if (cnt_ext > (CW+COUNT_W+1)'(COUNT_MAX)) begin
         count_in = COUNT_MAX;
      end else begin
         count_in = cnt_ext[COUNT_W-1:0];
      end
   end

   always_comb begin
      wr_entry.ip_high = ip_high_ff;
      wr_entry.ip_low  = ip_low_ff;
      wr_entry.mac     = mac_ff;
      wr_entry.stamp   = now_ff;
      wr_entry.router  = router_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end else if (clear_en) begin
         valid_ff[match_idx_ff] <= 1'b0;
      end
   end

   // result register
   logic                out_valid_ff;
   logic                hit_ff;
   logic                expired_ff;
   logic [MAC_W-1:0]    mac_out_ff;
   logic                router_out_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [COUNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff        <= hit_in;
         expired_ff    <= expired_in;
         mac_out_ff    <= mac_out_in;
         router_out_ff <= router_out_in;
         slot_ff       <= slot_ext[SLOT_W-1:0];
         count_ff      <= count_in;
      end
   end

   assign status.out_free = !out_valid_ff || !rsp_stall;
   assign rsp_valid       = out_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_expired     = expired_ff;
   assign rsp_mac_out     = mac_out_ff;
   assign rsp_router_out  = router_out_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_live_count  = count_ff;

`ifndef SYNTH
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result word not presented");

   a_reads_done: assert property (@(posedge clock) disable iff (reset)
      status.scan_done |-> !rd_busy_ff)
      else $error("scan ended with reads outstanding");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff <= CW'(ENTRIES))
      else $error("live count beyond table size");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.commit)
      else $error("result word overwritten while stalled");
`endif

endmodule
